### sv/tspat_pkg.sv
// ----------------------------------------------------------------------------
// tspat_pkg - shared types and codes for the PAT section parser
// Result kinds, error codes and the result record passed from the parse
// core to the top level.
// ----------------------------------------------------------------------------
package tspat_pkg;

   // result kinds
   localparam logic [1:0] KIND_ENTRY    = 2'd0;
   localparam logic [1:0] KIND_COMPLETE = 2'd1;
   localparam logic [1:0] KIND_ERROR    = 2'd2;

   // error codes
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_TABLE_ID  = 2'd1;
   localparam logic [1:0] ERR_TRUNCATED = 2'd2;
   localparam logic [1:0] ERR_SHORT_LEN = 2'd3;

   // smallest legal section length (header after length plus CRC)
   localparam logic [11:0] MIN_SECTION_LEN = 12'd9;

   // table id of a program association table
   localparam logic [7:0] PAT_TABLE_ID = 8'h00;

   // packed result widths
   localparam int RSP_DATA_W = 120;
   localparam int RSP_USER_W = 2;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [15:0] program_number;
      logic [12:0] entry_pid;
      logic [15:0] stream_id;
      logic [4:0]  version;
      logic        current_next;
      logic        syntax_bit;
      logic [7:0]  section_index;
      logic [7:0]  last_section_index;
      logic [11:0] section_length;
      logic [31:0] section_crc;
      logic [1:0]  error_code;
   } tspat_result_type;

endpackage

### sv/ts_pat_section_parser.sv
// ----------------------------------------------------------------------------
// ts_pat_section_parser - program association table section parser
// Streams a PAT section in one byte per transfer and streams out one record
// per program entry, one at section end, or one error record.
// ----------------------------------------------------------------------------
// The block takes one section byte per clock cycle and sustains that rate as
// long as the result side keeps rsp_tready high. A byte waits in the input
// register until its result, if any, has room in the result register, which
// drives rsp_tvalid (one input register, one result register). Set req_tuser
// on the table id byte to start a section and req_tlast on the last byte
// available. Each four-byte entry yields an entry record, the fourth CRC byte
// yields a completion record carrying the CRC as read (not checked), and a bad
// table id, a section length below 9, or an early req_tlast yields an error
// record and drops the section. Bytes outside a section are discarded.
module ts_pat_section_parser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // [7:0] data_byte
   input  logic                              req_tlast,  // buffer_end
   input  logic                              req_tuser,  // section_start
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [15:0] program_number, [28:16] entry_pid, [44:29] stream_id,
   // [49:45] version, [50] current_next, [51] syntax_bit,
   // [59:52] section_index, [67:60] last_section_index,
   // [79:68] section_length, [111:80] section_crc, [113:112] error_code,
   // [119:114] zero
   output logic [tspat_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [tspat_pkg::RSP_USER_W-1:0]  rsp_tuser   // [1:0] result_kind
);
   import tspat_pkg::*;

   logic             s1_valid_ff, s1_valid_in;
   logic [7:0]       s1_byte_ff;
   logic             s1_start_ff;
   logic             s1_end_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   tspat_result_type rsp_ff;
   logic             step;
   logic             out_free;
   logic             res_valid;
   tspat_result_type res;

   tspat_core u_core (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .data_byte     (s1_byte_ff),
      .section_start (s1_start_ff),
      .buffer_end    (s1_end_ff),
      .res_valid     (res_valid),
      .res           (res)
   );

   // advance the held byte when its result, if any, has a place to go
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign step         = s1_valid_ff && (!res_valid || out_free);
   assign req_tready   = !s1_valid_ff || step;
   assign s1_valid_in  = req_tvalid || (s1_valid_ff && !step);
   assign rsp_valid_in = out_free ? (step && res_valid) : rsp_valid_ff;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_byte_ff  <= req_tdata;
         s1_start_ff <= req_tuser;
         s1_end_ff   <= req_tlast;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res_valid && out_free) begin
         rsp_ff <= res;
      end
   end

   // pack the transfer
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.result_kind;
   assign rsp_tdata  = {6'd0,
                        rsp_ff.error_code,
                        rsp_ff.section_crc,
                        rsp_ff.section_length,
                        rsp_ff.last_section_index,
                        rsp_ff.section_index,
                        rsp_ff.syntax_bit,
                        rsp_ff.current_next,
                        rsp_ff.version,
                        rsp_ff.stream_id,
                        rsp_ff.entry_pid,
                        rsp_ff.program_number};

endmodule

### sv/tspat_core.sv
// ----------------------------------------------------------------------------
// tspat_core - byte-wise PAT section field extractor
// Walks the section header, entries and CRC one byte per step and returns
// at most one result record for each byte.
// ----------------------------------------------------------------------------
module tspat_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [7:0]                  data_byte,
   input  logic                        section_start,
   input  logic                        buffer_end,
   output logic                        res_valid,
   output tspat_pkg::tspat_result_type res
);
   import tspat_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_TSID_HI,
      PH_TSID_LO,
      PH_VER,
      PH_SEC,
      PH_LAST,
      PH_ENTRY,
      PH_CRC
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [1:0]  pos_ff, pos_in;
   logic [9:0]  entries_ff, entries_in;
   logic [11:0] length_ff, length_in;
   logic [15:0] sid_ff, sid_in;
   logic        syntax_ff, syntax_in;
   logic [4:0]  version_ff, version_in;
   logic        cn_ff, cn_in;
   logic [7:0]  sec_ff, sec_in;
   logic [7:0]  last_ff, last_in;
   logic [31:0] shift_ff, shift_in;

   logic [11:0] len_full;
   logic [11:0] len_excess;
   logic [31:0] shifted;
   logic        trunc_check;

   // header fields shared by entry and completion results
   function automatic tspat_result_type header_rec(
      input logic [1:0]  kind,
      input logic [15:0] prog,
      input logic [12:0] pid,
      input logic [31:0] crc,
      input logic [15:0] sid,
      input logic [4:0]  ver,
      input logic        cn,
      input logic        syn,
      input logic [7:0]  sec,
      input logic [7:0]  lst,
      input logic [11:0] len
   );
      tspat_result_type r;
      r.result_kind        = kind;
      r.program_number     = prog;
      r.entry_pid          = pid;
      r.stream_id          = sid;
      r.version            = ver;
      r.current_next       = cn;
      r.syntax_bit         = syn;
      r.section_index      = sec;
      r.last_section_index = lst;
      r.section_length     = len;
      r.section_crc        = crc;
      r.error_code         = ERR_NONE;
      return r;
   endfunction

   assign len_full   = {length_ff[11:8], data_byte};
   assign len_excess = len_full - MIN_SECTION_LEN;
   assign shifted    = {shift_ff[23:0], data_byte};

   // decode one byte
   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      entries_in  = entries_ff;
      length_in   = length_ff;
      sid_in      = sid_ff;
      syntax_in   = syntax_ff;
      version_in  = version_ff;
      cn_in       = cn_ff;
      sec_in      = sec_ff;
      last_in     = last_ff;
      shift_in    = shift_ff;
      res_valid   = 1'b0;
      res         = '0;
      trunc_check = 1'b0;

      if (section_start) begin
         if (data_byte != PAT_TABLE_ID) begin
            res_valid      = 1'b1;
            res.result_kind = KIND_ERROR;
            res.error_code  = ERR_TABLE_ID;
            phase_in       = PH_IDLE;
         end else begin
            pos_in      = 2'd0;
            entries_in  = '0;
            shift_in    = '0;
            phase_in    = PH_LEN_HI;
            trunc_check = 1'b1;
         end
      end else begin
         unique case (phase_ff)
            PH_IDLE: begin
               phase_in = PH_IDLE;
            end
            PH_LEN_HI: begin
               syntax_in   = data_byte[7];
               length_in   = {data_byte[3:0], 8'h00};
               phase_in    = PH_LEN_LO;
               trunc_check = 1'b1;
            end
            PH_LEN_LO: begin
               length_in = len_full;
               if (len_full < MIN_SECTION_LEN) begin
                  res_valid       = 1'b1;
                  res.result_kind = KIND_ERROR;
                  res.error_code  = ERR_SHORT_LEN;
                  phase_in        = PH_IDLE;
               end else begin
                  entries_in  = len_excess[11:2];
                  phase_in    = PH_TSID_HI;
                  trunc_check = 1'b1;
               end
            end
            PH_TSID_HI: begin
               sid_in      = {data_byte, 8'h00};
               phase_in    = PH_TSID_LO;
               trunc_check = 1'b1;
            end
            PH_TSID_LO: begin
               sid_in      = {sid_ff[15:8], data_byte};
               phase_in    = PH_VER;
               trunc_check = 1'b1;
            end
            PH_VER: begin
               version_in  = data_byte[5:1];
               cn_in       = data_byte[0];
               phase_in    = PH_SEC;
               trunc_check = 1'b1;
            end
            PH_SEC: begin
               sec_in      = data_byte;
               phase_in    = PH_LAST;
               trunc_check = 1'b1;
            end
            PH_LAST: begin
               last_in     = data_byte;
               pos_in      = 2'd0;
               shift_in    = '0;
               phase_in    = (entries_ff == '0) ? PH_CRC : PH_ENTRY;
               trunc_check = 1'b1;
            end
            PH_ENTRY: begin
               shift_in = shifted;
               if (pos_ff != 2'd3) begin
                  pos_in      = pos_ff + 2'd1;
                  trunc_check = 1'b1;
               end else begin
                  pos_in     = 2'd0;
                  entries_in = entries_ff - 10'd1;
                  if (entries_in == '0) begin
                     phase_in = PH_CRC;
                  end
                  if (buffer_end) begin
                     res_valid       = 1'b1;
                     res.result_kind = KIND_ERROR;
                     res.error_code  = ERR_TRUNCATED;
                     phase_in        = PH_IDLE;
                  end else begin
                     shift_in  = '0;
                     res_valid = 1'b1;
                     res = header_rec(KIND_ENTRY, shifted[31:16], shifted[12:0], '0,
                                      sid_ff, version_ff, cn_ff, syntax_ff,
                                      sec_ff, last_ff, length_ff);
                  end
               end
            end
            PH_CRC: begin
               shift_in = shifted;
               if (pos_ff != 2'd3) begin
                  pos_in      = pos_ff + 2'd1;
                  trunc_check = 1'b1;
               end else begin
                  pos_in    = 2'd0;
                  phase_in  = PH_IDLE;
                  res_valid = 1'b1;
                  res = header_rec(KIND_COMPLETE, '0, '0, shifted,
                                   sid_ff, version_ff, cn_ff, syntax_ff,
                                   sec_ff, last_ff, length_ff);
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end

      // drop the section when the buffer runs out early
      if (trunc_check && buffer_end) begin
         res_valid       = 1'b1;
         res             = '0;
         res.result_kind = KIND_ERROR;
         res.error_code  = ERR_TRUNCATED;
         phase_in        = PH_IDLE;
      end
   end

   // hold parse state; advance only on a processed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         pos_ff     <= 2'd0;
         entries_ff <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         entries_ff <= entries_in;
         length_ff  <= length_in;
         sid_ff     <= sid_in;
         syntax_ff  <= syntax_in;
         version_ff <= version_in;
         cn_ff      <= cn_in;
         sec_ff     <= sec_in;
         last_ff    <= last_in;
         shift_ff   <= shift_in;
      end
   end

endmodule

### tb/ts_pat_section_parser_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ts_pat_section_parser_tb - self-checking bench for the PAT section parser
// Feeds section bytes over the request stream, first from a short table of
// hand-picked cases, then as random sections mixed with noise and broken
// sections. A behavioral parser predicts each record unless a table row sets
// its own; each record that arrives on the result stream is checked field by field.
// ----------------------------------------------------------------------------
module ts_pat_section_parser_tb;
   import tspat_pkg::*;

   localparam int RANDOM_BYTES = 800;
   localparam int HOLD_CYCLES  = 300;
   localparam int LIMIT_CYCLES = 100000;

   typedef enum logic [3:0] {
      PS_IDLE, PS_LEN_HI, PS_LEN_LO, PS_TSID_HI, PS_TSID_LO,
      PS_VER, PS_SEC, PS_LAST, PS_ENTRY, PS_CRC
   } parse_state_type;

   // how a table row gets its expectation
   typedef enum logic [1:0] {CHK_MODEL, CHK_SILENT, CHK_ERROR} row_check_type;

   typedef struct {
      logic [7:0]    data;
      logic          sos;
      logic          eob;
      row_check_type chk;
      logic [1:0]    err;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;
   logic                  req_tlast;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   // predictor state
   parse_state_type ps_state;
   logic [1:0]      ps_pos;
   logic [9:0]      ps_left;
   logic [11:0]     ps_len;
   logic [15:0]     ps_tsid;
   logic [6:0]      ps_flags;
   logic [15:0]     ps_secn;
   logic [31:0]     ps_shift;

   tspat_result_type pending_records[$];
   stim_row_type     directed_rows[$];
   tspat_result_type got;

   int unsigned bytes_sent;
   int unsigned fail_total;
   int unsigned cycle_count;
   int unsigned hold_req;
   int unsigned hold_seen;
   int unsigned hold_left;
   bit          quiet;

   ts_pat_section_parser u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic tspat_result_type error_record(input logic [1:0] code);
      tspat_result_type r;
      r             = '0;
      r.result_kind = KIND_ERROR;
      r.error_code  = code;
      return r;
   endfunction

   function automatic tspat_result_type header_record(input logic [1:0] kind,
         input logic [15:0] prog, input logic [12:0] pid, input logic [31:0] crc);
      tspat_result_type r;
      r.result_kind        = kind;
      r.program_number     = prog;
      r.entry_pid          = pid;
      r.stream_id          = ps_tsid;
      r.version            = ps_flags[5:1];
      r.current_next       = ps_flags[0];
      r.syntax_bit         = ps_flags[6];
      r.section_index      = ps_secn[15:8];
      r.last_section_index = ps_secn[7:0];
      r.section_length     = ps_len;
      r.section_crc        = crc;
      r.error_code         = ERR_NONE;
      return r;
   endfunction

   // advance the predicted parse by one byte; return 1 when a record is due
   function automatic bit parse_byte(input logic [7:0] b, input logic sos,
         input logic eob, output tspat_result_type r);
      logic [31:0] word;
      r = '0;
      if (sos) begin
         if (b != PAT_TABLE_ID) begin
            ps_state = PS_IDLE;
            r = error_record(ERR_TABLE_ID);
            return 1'b1;
         end
         ps_len   = '0;
         ps_tsid  = '0;
         ps_flags = '0;
         ps_secn  = '0;
         ps_shift = '0;
         ps_pos   = '0;
         ps_left  = '0;
         ps_state = PS_LEN_HI;
         if (eob) begin
            ps_state = PS_IDLE;
            r = error_record(ERR_TRUNCATED);
            return 1'b1;
         end
         return 1'b0;
      end
      case (ps_state)
         PS_LEN_HI: begin
            ps_flags[6] = b[7];
            ps_len      = {b[3:0], 8'h00};
            ps_state    = PS_LEN_LO;
         end
         PS_LEN_LO: begin
            ps_len[7:0] = b;
            if (ps_len < MIN_SECTION_LEN) begin
               ps_state = PS_IDLE;
               r = error_record(ERR_SHORT_LEN);
               return 1'b1;
            end
            ps_left  = 10'((ps_len - MIN_SECTION_LEN) / 4);
            ps_state = PS_TSID_HI;
         end
         PS_TSID_HI: begin
            ps_tsid  = {b, 8'h00};
            ps_state = PS_TSID_LO;
         end
         PS_TSID_LO: begin
            ps_tsid[7:0] = b;
            ps_state     = PS_VER;
         end
         PS_VER: begin
            ps_flags[5:0] = b[5:0];
            ps_state      = PS_SEC;
         end
         PS_SEC: begin
            ps_secn  = {b, 8'h00};
            ps_state = PS_LAST;
         end
         PS_LAST: begin
            ps_secn[7:0] = b;
            ps_pos       = '0;
            ps_shift     = '0;
            ps_state     = (ps_left == 0) ? PS_CRC : PS_ENTRY;
         end
         PS_ENTRY: begin
            ps_shift = {ps_shift[23:0], b};
            if (ps_pos < 3) begin
               ps_pos = ps_pos + 2'd1;
            end else begin
               ps_pos  = '0;
               ps_left = ps_left - 10'd1;
               if (ps_left == 0) ps_state = PS_CRC;
               if (eob) begin
                  ps_state = PS_IDLE;
                  r = error_record(ERR_TRUNCATED);
                  return 1'b1;
               end
               word     = ps_shift;
               ps_shift = '0;
               r = header_record(KIND_ENTRY, word[31:16], word[12:0], 32'h0);
               return 1'b1;
            end
         end
         PS_CRC: begin
            ps_shift = {ps_shift[23:0], b};
            if (ps_pos < 3) begin
               ps_pos = ps_pos + 2'd1;
            end else begin
               ps_pos   = '0;
               ps_state = PS_IDLE;
               r = header_record(KIND_COMPLETE, 16'h0, 13'h0, ps_shift);
               return 1'b1;
            end
         end
         default: begin
            // drop bytes outside a section
            ps_state = PS_IDLE;
            return 1'b0;
         end
      endcase
      if (eob) begin
         ps_state = PS_IDLE;
         r = error_record(ERR_TRUNCATED);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic add_row(input logic [7:0] data, input logic sos, input logic eob,
         input row_check_type chk, input logic [1:0] err);
      stim_row_type row;
      row.data = data;
      row.sos  = sos;
      row.eob  = eob;
      row.chk  = chk;
      row.err  = err;
      directed_rows.push_back(row);
   endtask

   // offer one byte with random idle cycles, then predict on the transfer
   task automatic send_byte(input logic [7:0] b, input logic sos, input logic eob,
         input row_check_type chk, input logic [1:0] err);
      tspat_result_type r;
      bit               due;
      while (!quiet && $urandom_range(0, 99) < 38) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= sos;
      req_tlast  <= eob;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (sos || ps_state != PS_IDLE) bytes_sent++;
      due = parse_byte(b, sos, eob, r);
      if (chk == CHK_SILENT) due = 1'b0;
      if (chk == CHK_ERROR) begin
         due = 1'b1;
         r   = error_record(err);
      end
      if (due) pending_records.push_back(r);
      @(negedge clock);
   endtask

   // random section: mostly well formed, sometimes cut short or abandoned
   task automatic send_section();
      logic [7:0]  body[$];
      logic [11:0] len;
      logic [7:0]  hi;
      int unsigned n_entries, stop, pick, top;
      bit          eob_last;
      pick = $urandom_range(0, 99);
      if (pick < 80) len = 12'($urandom_range(9, 45));
      else if (pick < 90) len = 12'($urandom_range(0, 8));
      else len = 12'($urandom_range(0, 4095));
      body.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom_range(1, 255))
                                                  : PAT_TABLE_ID);
      hi      = 8'($urandom_range(0, 255));
      hi[3:0] = len[11:8];
      body.push_back(hi);
      body.push_back(len[7:0]);
      n_entries = 0;
      if (len >= MIN_SECTION_LEN) begin
         n_entries = 32'((len - MIN_SECTION_LEN) / 4);
         repeat (5) body.push_back(8'($urandom_range(0, 255)));
         for (int e = 0; e < n_entries && e < 12; e++) begin
            if ($urandom_range(0, 7) == 0) begin
               body.push_back(8'h00);
               body.push_back(8'h00);
            end else begin
               body.push_back(8'($urandom_range(0, 255)));
               body.push_back(8'($urandom_range(0, 255)));
            end
            body.push_back(8'($urandom_range(0, 255)));
            body.push_back(8'($urandom_range(0, 255)));
         end
         repeat (4) body.push_back(8'($urandom_range(0, 255)));
      end
      stop     = body.size() - 1;
      eob_last = 1'($urandom_range(0, 1));
      top      = (stop < 40) ? stop : 40;
      if (n_entries > 8 || $urandom_range(0, 9) == 0) begin
         stop     = $urandom_range(0, top);
         eob_last = 1'b1;
      end else if ($urandom_range(0, 19) == 0) begin
         // abandon mid-section; the next start restarts the parse
         stop     = $urandom_range(0, top);
         eob_last = 1'b0;
      end
      for (int i = 0; i <= stop; i++)
         send_byte(body[i], i == 0, (i == stop) && eob_last, CHK_MODEL, ERR_NONE);
   endtask

   task automatic send_noise();
      int unsigned n;
      n = $urandom_range(1, 6);
      repeat (n)
         send_byte($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255)),
                   $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                   CHK_MODEL, ERR_NONE);
   endtask

   // stimulus and end of run
   initial begin
      bit hold_fired;
      bit drained;
      hold_fired = 1'b0;
      drained    = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      req_tuser  = 1'b0;
      quiet      = 1'b0;
      hold_req   = 0;
      bytes_sent = 0;
      ps_state   = PS_IDLE;
      ps_pos     = '0;
      ps_left    = '0;
      ps_len     = '0;
      ps_tsid    = '0;
      ps_flags   = '0;
      ps_secn    = '0;
      ps_shift   = '0;

      // byte outside a section, bad table id, start cut short
      add_row(8'h55, 1'b0, 1'b0, CHK_SILENT, ERR_NONE);
      add_row(8'hFF, 1'b1, 1'b0, CHK_ERROR,  ERR_TABLE_ID);
      add_row(8'h00, 1'b1, 1'b1, CHK_ERROR,  ERR_TRUNCATED);
      // short length, also when the length byte ends the buffer
      add_row(8'h00, 1'b1, 1'b0, CHK_SILENT, ERR_NONE);
      add_row(8'hF0, 1'b0, 1'b0, CHK_SILENT, ERR_NONE);
      add_row(8'h08, 1'b0, 1'b0, CHK_ERROR,  ERR_SHORT_LEN);
      add_row(8'h00, 1'b1, 1'b0, CHK_SILENT, ERR_NONE);
      add_row(8'h00, 1'b0, 1'b0, CHK_SILENT, ERR_NONE);
      add_row(8'h05, 1'b0, 1'b1, CHK_ERROR,  ERR_SHORT_LEN);
      // one-entry section, all header bits high, network PID entry
      add_row(8'h00, 1'b1, 1'b0, CHK_SILENT, ERR_NONE);
      add_row(8'hB0, 1'b0, 1'b0, CHK_SILENT, ERR_NONE);
      add_row(8'h0D, 1'b0, 1'b0, CHK_SILENT, ERR_NONE);
      repeat (5) add_row(8'hFF, 1'b0, 1'b0, CHK_SILENT, ERR_NONE);
      add_row(8'h00, 1'b0, 1'b0, CHK_SILENT, ERR_NONE);
      add_row(8'h00, 1'b0, 1'b0, CHK_SILENT, ERR_NONE);
      add_row(8'hFF, 1'b0, 1'b0, CHK_SILENT, ERR_NONE);
      add_row(8'hFF, 1'b0, 1'b0, CHK_MODEL,  ERR_NONE);
      add_row(8'hDE, 1'b0, 1'b0, CHK_SILENT, ERR_NONE);
      add_row(8'hAD, 1'b0, 1'b0, CHK_SILENT, ERR_NONE);
      add_row(8'hBE, 1'b0, 1'b0, CHK_SILENT, ERR_NONE);
      add_row(8'hEF, 1'b0, 1'b1, CHK_MODEL,  ERR_NONE);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_byte(directed_rows[i].data, directed_rows[i].sos, directed_rows[i].eob,
                   directed_rows[i].chk, directed_rows[i].err);

      while (bytes_sent < directed_rows.size() + RANDOM_BYTES) begin
         quiet = (bytes_sent >= 300 && bytes_sent < 450);
         if (!hold_fired && bytes_sent >= 200) begin
            hold_req++;
            hold_fired = 1'b1;
         end
         // pause the sender until every pending record is out
         if (!drained && bytes_sent >= 600) begin
            while (pending_records.size() != 0) begin
               req_tvalid <= 1'b0;
               @(negedge clock);
            end
            drained = 1'b1;
         end
         if ($urandom_range(0, 3) == 0) send_noise();
         else send_section();
      end

      quiet = 1'b0;
      req_tvalid <= 1'b0;
      while (pending_records.size() != 0) @(negedge clock);
      repeat (10) @(posedge clock);
      if (fail_total == 0)
         $display("ts_pat_section_parser test passed");
      else
         $display("ts_pat_section_parser test failed");
      $finish;
   end

   // result side ready, with random stalls and one long hold-off
   initial begin
      rsp_tready = 1'b0;
      hold_seen  = 0;
      hold_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet || ($urandom_range(0, 99) >= 38);
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
         input logic [31:0] have);
      if (want !== have) begin
         fail_total++;
         if (fail_total <= 10)
            $display("mismatch %s: expected %0h got %0h at %0t", name, want, have, $time);
      end
   endtask

   // compare each result transfer with the oldest pending record
   always @(posedge clock) begin
      tspat_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.result_kind        = rsp_tuser[1:0];
         got.program_number     = rsp_tdata[15:0];
         got.entry_pid          = rsp_tdata[28:16];
         got.stream_id          = rsp_tdata[44:29];
         got.version            = rsp_tdata[49:45];
         got.current_next       = rsp_tdata[50];
         got.syntax_bit         = rsp_tdata[51];
         got.section_index      = rsp_tdata[59:52];
         got.last_section_index = rsp_tdata[67:60];
         got.section_length     = rsp_tdata[79:68];
         got.section_crc        = rsp_tdata[111:80];
         got.error_code         = rsp_tdata[113:112];
         if (pending_records.size() == 0) begin
            fail_total++;
            if (fail_total <= 10)
               $display("unexpected record kind %0d at %0t", got.result_kind, $time);
         end else begin
            want = pending_records.pop_front();
            check_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
            check_field("program_number", 32'(want.program_number),
                        32'(got.program_number));
            check_field("entry_pid", 32'(want.entry_pid), 32'(got.entry_pid));
            check_field("stream_id", 32'(want.stream_id), 32'(got.stream_id));
            check_field("version", 32'(want.version), 32'(got.version));
            check_field("current_next", 32'(want.current_next), 32'(got.current_next));
            check_field("syntax_bit", 32'(want.syntax_bit), 32'(got.syntax_bit));
            check_field("section_index", 32'(want.section_index),
                        32'(got.section_index));
            check_field("last_section_index", 32'(want.last_section_index),
                        32'(got.last_section_index));
            check_field("section_length", 32'(want.section_length),
                        32'(got.section_length));
            check_field("section_crc", want.section_crc, got.section_crc);
            check_field("error_code", 32'(want.error_code), 32'(got.error_code));
            check_field("pad", 32'h0, 32'(rsp_tdata[119:114]));
         end
      end
   end

   // stop a hung run
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("ts_pat_section_parser test failed");
         $finish;
      end
   end

endmodule
